### src/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types, register codes and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int DIM_MIN        = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;

    localparam int PIX_W      = 8;
    localparam int GRAD_ABS_W = 10;
    localparam int SQ_W       = 21;
    localparam int ROOT_W     = SQ_W + 1;
    localparam int T_W        = 11;

    localparam logic [ROOT_W-1:0] ROOT_BIT_TOP = ROOT_W'(1) << (SQ_W - 1);
    localparam logic [PIX_W-1:0]  MAG_SAT      = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             drain;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic             last;
    } t_mag_out;

    function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v, input int hi);
        int x;
        x = int'(v);
        if (x < DIM_MIN) return DIM_MIN;
        if (x > hi) return hi;
        return x;
    endfunction

endpackage

### src/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/sem_mag.sv
// ----------------------------------------------------------------------------
// sem_mag
// Sum of squares, bit-serial integer square root, halving with round to
// nearest even and saturation to 8 bits.
// ----------------------------------------------------------------------------
module sem_mag (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [sem_pkg::GRAD_ABS_W-1:0]   i_abs_gx,
    input  logic [sem_pkg::GRAD_ABS_W-1:0]   i_abs_gy,
    output logic                             o_done,
    output logic [sem_pkg::PIX_W-1:0]        o_mag
);

    import sem_pkg::*;

    typedef enum logic [4:0] {
        M_IDLE  = 5'b00001,
        M_SQX   = 5'b00010,
        M_SQY   = 5'b00100,
        M_ROOT  = 5'b01000,
        M_ROUND = 5'b10000
    } t_mag_state;

    t_mag_state r_state;

    logic [GRAD_ABS_W-1:0]   r_ax;
    logic [GRAD_ABS_W-1:0]   r_ay;
    logic [SQ_W-1:0]         r_s;
    logic [ROOT_W-1:0]       r_root;
    logic [ROOT_W-1:0]       r_bit;
    logic [PIX_W-1:0]        r_mag;
    logic                    r_done;

    logic [GRAD_ABS_W-1:0]   mul_a;
    logic [2*GRAD_ABS_W-1:0] prod;
    logic [ROOT_W-1:0]       trial;
    logic [T_W-1:0]          t_val;
    logic [T_W-1:0]          n_val;
    logic                    tie;
    logic [T_W-1:0]          n_round;

    // one shared squarer
    assign mul_a = (r_state == M_SQX) ? r_ax : r_ay;
    assign prod  = mul_a * mul_a;
    assign trial = r_root + r_bit;

    always_comb begin
        t_val = r_root[T_W-1:0];
        n_val = (t_val + T_W'(1)) >> 1;
        tie   = (r_s == '0) && t_val[0] && n_val[0];
        n_round = tie ? (n_val - T_W'(1)) : n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_state <= M_SQX;
                    end
                end
                M_SQX: begin
                    r_state <= M_SQY;
                end
                M_SQY: begin
                    r_state <= M_ROOT;
                end
                M_ROOT: begin
                    if (r_bit[0]) begin
                        r_state <= M_ROUND;
                    end
                end
                M_ROUND: begin
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    r_ax <= i_abs_gx;
                    r_ay <= i_abs_gy;
                end
            end
            M_SQX: begin
                r_s <= SQ_W'(prod);
            end
            M_SQY: begin
                r_s    <= r_s + SQ_W'(prod);
                r_root <= '0;
                r_bit  <= ROOT_BIT_TOP;
            end
            M_ROOT: begin
                if (ROOT_W'(r_s) >= trial) begin
                    r_s    <= r_s - SQ_W'(trial);
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            M_ROUND: begin
                r_mag <= (n_round > T_W'(MAG_SAT)) ? MAG_SAT : n_round[PIX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_mag  = r_mag;

endmodule

### src/sobel_edge_magnitude_top.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_top
// Streaming 3x3 Sobel half gradient magnitude over raster-order grey pixels.
//
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_stall  t_pix_in  (pixel, drain)
//   out      output     o_out_valid/i_out_stall t_mag_out (magnitude, last)
//   cfg      input      i_cfg_we               i_cfg_idx, i_cfg_data
//
// one transaction at a time; an interior pixel waits in S_CALC for the
// 11 iterations of the bit-serial square root in sem_mag; a border pixel
// passes S_READ and S_HOLD, a drain result S_HOLD, a pixel without one S_READ
// the two line stores are read in the accept cycle and written in the cycle after it
// line stores are not cleared by reset; counters and window are, sizes return to their reset values
// a held result does not block the next input transaction
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  sem_pkg::t_pix_in                i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output sem_pkg::t_mag_out               o_out,
    input  logic                            i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import sem_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    localparam logic [WW-1:0] W_RST    = WW'(clamp_dim(WIDTH_RESET, MAX_WIDTH));
    localparam logic [RW-1:0] H_RST    = RW'(clamp_dim(HEIGHT_RESET, MAX_HEIGHT));
    localparam logic [RW-1:0] ROW_SAT  = RW'(MAX_HEIGHT + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CALC = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state r_state;

    logic [WW-1:0] r_w;
    logic [RW-1:0] r_h;
    logic [CW-1:0] r_ic;
    logic [RW-1:0] r_ir;
    logic [CW-1:0] r_oc;
    logic [RW-1:0] r_or;

    logic [PIX_W-1:0] r_win [6];

    logic [CW-1:0]    r_c;
    logic [PIX_W-1:0] r_pix;
    logic             r_emit;
    logic             r_interior;
    logic             r_last;
    logic [PIX_W-1:0] r_res_mag;

    logic             r_out_valid;
    t_mag_out         r_out;

    logic [WW-1:0] ic_a, oc_a, ic_n, oc_n;
    logic [RW-1:0] ir_a, or_a, ir_n, or_n;
    logic          in_frame, emit, interior, last;
    logic          accept;

    logic [PIX_W-1:0] top_pix, mid_pix;
    logic [GRAD_ABS_W-1:0] pos_x, neg_x, pos_y, neg_y;
    logic signed [GRAD_ABS_W:0] gx, gy, gx_abs, gy_abs;
    logic mag_start, mag_done;
    logic [PIX_W-1:0] mag_val;
    logic ram_we;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // counter wrap, frame restart and advance for one transaction
    always_comb begin
        ic_a = WW'(r_ic);
        ir_a = r_ir;
        oc_a = WW'(r_oc);
        or_a = r_or;
        if (ic_a >= r_w) begin
            ic_a = '0;
            if (ir_a < ROW_SAT) ir_a = ir_a + RW'(1);
        end
        if (oc_a >= r_w) begin
            oc_a = '0;
            or_a = or_a + RW'(1);
        end
        if (or_a >= r_h) begin
            ic_a = '0;
            ir_a = '0;
            oc_a = '0;
            or_a = '0;
        end
        in_frame = (ir_a < r_h);
        emit     = (ir_a >= RW'(2)) || ((ir_a == RW'(1)) && (ic_a != '0));
        interior = (or_a != '0) && ((or_a + RW'(1)) < r_h) &&
                   (oc_a != '0) && ((oc_a + WW'(1)) < r_w);
        last     = ((or_a + RW'(1)) == r_h) && ((oc_a + WW'(1)) == r_w);
        ic_n = ic_a;
        ir_n = ir_a;
        oc_n = oc_a;
        or_n = or_a;
        if (!(i_in.drain && in_frame)) begin
            ic_n = ic_a + WW'(1);
            if (ic_n >= r_w) begin
                ic_n = '0;
                if (ir_n < ROW_SAT) ir_n = ir_n + RW'(1);
            end
            if (emit) begin
                if (last) begin
                    ic_n = '0;
                    ir_n = '0;
                    oc_n = '0;
                    or_n = '0;
                end else begin
                    oc_n = oc_a + WW'(1);
                    if (oc_n >= r_w) begin
                        oc_n = '0;
                        or_n = or_a + RW'(1);
                    end
                end
            end
        end
    end

    // window and gradients, valid in the read cycle
    always_comb begin
        pos_x = GRAD_ABS_W'(top_pix) + (GRAD_ABS_W'(mid_pix) << 1) + GRAD_ABS_W'(r_pix);
        neg_x = GRAD_ABS_W'(r_win[0]) + (GRAD_ABS_W'(r_win[1]) << 1) +
                GRAD_ABS_W'(r_win[2]);
        pos_y = GRAD_ABS_W'(r_win[2]) + (GRAD_ABS_W'(r_win[5]) << 1) + GRAD_ABS_W'(r_pix);
        neg_y = GRAD_ABS_W'(r_win[0]) + (GRAD_ABS_W'(r_win[3]) << 1) + GRAD_ABS_W'(top_pix);
        gx = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
        gy = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
        gx_abs = gx[GRAD_ABS_W] ? -gx : gx;
        gy_abs = gy[GRAD_ABS_W] ? -gy : gy;
    end

    assign ram_we    = (r_state == S_READ);
    assign mag_start = (r_state == S_READ) && r_emit && r_interior;

    // row above
    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row1 (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_c),
        .i_wdata (r_pix),
        .i_raddr (CW'(ic_a)),
        .o_rdata (mid_pix)
    );

    // two rows above
    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row2 (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_c),
        .i_wdata (mid_pix),
        .i_raddr (CW'(ic_a)),
        .o_rdata (top_pix)
    );

    sem_mag u_mag (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mag_start),
        .i_abs_gx (gx_abs[GRAD_ABS_W-1:0]),
        .i_abs_gy (gy_abs[GRAD_ABS_W-1:0]),
        .o_done   (mag_done),
        .o_mag    (mag_val)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_w         <= W_RST;
            r_h         <= H_RST;
            r_ic        <= '0;
            r_ir        <= '0;
            r_oc        <= '0;
            r_or        <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 6; k++) r_win[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_WIDTH:  r_w <= WW'(clamp_dim(i_cfg_data, MAX_WIDTH));
                    REG_FRAME_HEIGHT: r_h <= RW'(clamp_dim(i_cfg_data, MAX_HEIGHT));
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && !i_out_stall && (r_state != S_HOLD)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ic <= CW'(ic_n);
                        r_ir <= ir_n;
                        r_oc <= CW'(oc_n);
                        r_or <= or_n;
                        if (i_in.drain && in_frame) begin
                            r_state <= S_IDLE;
                        end else if (in_frame) begin
                            r_state <= S_READ;
                        end else if (emit) begin
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_READ: begin
                    r_win[0] <= r_win[3];
                    r_win[1] <= r_win[4];
                    r_win[2] <= r_win[5];
                    r_win[3] <= top_pix;
                    r_win[4] <= mid_pix;
                    r_win[5] <= r_pix;
                    if (r_emit && r_interior) begin
                        r_state <= S_CALC;
                    end else if (r_emit) begin
                        r_state <= S_HOLD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CALC: begin
                    if (mag_done) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && accept) begin
            r_c        <= CW'(ic_a);
            r_pix      <= i_in.pixel;
            r_emit     <= emit;
            r_interior <= interior && in_frame;
            r_last     <= last;
            r_res_mag  <= '0;
        end
        if ((r_state == S_CALC) && mag_done) begin
            r_res_mag <= mag_val;
        end
        if ((r_state == S_HOLD) && (!r_out_valid || !i_out_stall)) begin
            r_out.magnitude <= r_res_mag;
            r_out.last      <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
